/* rtl/core/mct_pkg.sv */
// shared constants, types and helper functions for the matrix concat/transform block
package mct_pkg;

   // number format
   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int ACC_BITS  = PROD_BITS + 2;

   // matrix geometry
   localparam int ELEMS     = 16;
   localparam int IDX_BITS  = 4;
   localparam int STEP_BITS = 6;

   // word range limits and the identity diagonal value
   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam int ONE_INT = (FRAC_BITS <= WORD_BITS - 2) ? (1 << FRAC_BITS)
                                                         : ((1 << (WORD_BITS - 1)) - 1);
   localparam logic signed [WORD_BITS-1:0] IDENT_ONE = WORD_BITS'(ONE_INT);

   // function selector codes
   localparam logic [1:0] FUNC_IDENTITY  = 2'd0;
   localparam logic [1:0] FUNC_LOAD      = 2'd1;
   localparam logic [1:0] FUNC_TRANSFORM = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_ACCEPTED    = 2'd0;
   localparam logic [1:0] STATUS_MULTIPLIED  = 2'd1;
   localparam logic [1:0] STATUS_TRANSFORMED = 2'd2;

   // sequencer step ends
   localparam logic [STEP_BITS-1:0] MUL_LAST_STEP   = 6'd63;
   localparam logic [STEP_BITS-1:0] XFORM_LAST_STEP = 6'd11;

   // tag that follows one multiply-accumulate through the pipeline
   typedef struct packed {
      logic                live;
      logic [1:0]          k;
      logic [IDX_BITS-1:0] dest;
   } mac_tag_type;

   // 32-bit input to the internal word width
   function automatic logic signed [WORD_BITS-1:0] word_from_in(input logic signed [31:0] v);
      logic signed [63:0] wide;
      wide = 64'(v);
      return wide[WORD_BITS-1:0];
   endfunction

   // internal word to the 32-bit result field
   function automatic logic signed [31:0] out_from_word(
         input logic signed [WORD_BITS-1:0] v);
      logic signed [63:0] wide;
      wide = 64'(v);
      return wide[31:0];
   endfunction

endpackage

/* rtl/core/mct_if.sv */
// request and response channel interfaces of the matrix concat/transform block
interface mct_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [3:0]         elem_index;
   logic signed [31:0] elem_value;
   logic               elem_last;
   logic signed [31:0] px;
   logic signed [31:0] py;
   logic signed [31:0] pz;

   modport source(output valid, output func, output elem_index, output elem_value,
                  output elem_last, output px, output py, output pz, input ready);
   modport sink(input valid, input func, input elem_index, input elem_value,
                input elem_last, input px, input py, input pz, output ready);
endinterface

interface mct_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               saturated;
   logic signed [31:0] qx;
   logic signed [31:0] qy;
   logic signed [31:0] qz;

   modport source(output valid, output status, output saturated, output qx, output qy,
                  output qz, input ready);
   modport sink(input valid, input status, input saturated, input qx, input qy,
                input qz, output ready);
endinterface

/* rtl/core/matrix4_concat_transform.sv */
// 4x4 fixed-point matrix concatenation and point transform unit
// Keeps a column-major 4x4 current matrix (Q16.16, reset to identity) and a right-hand
// operand matrix loaded one element per transaction. A transaction with func 1 and
// elem_last set multiplies current by operand into current; func 2 applies the upper-left
// 3x3 of current to (px,py,pz); func 0 reloads identity. Every request returns exactly one
// response. All arithmetic runs through one signed multiply-accumulate unit fed by a small
// sequencer, one product per cycle, with a four-stage read/multiply/add/round pipeline.
// A multiply runs 64 product steps and a point transform 12 steps, each followed by a drain
// of the pipeline; identity, plain loads and the unused selector go straight to the
// response. Requests are taken one at a time (ready only while idle),
// and a finished response waits in the output register without holding up the next request.
module matrix4_concat_transform import mct_pkg::*; (
   input logic         clock,
   input logic         reset,
   mct_req_if.sink     req_if,
   mct_rsp_if.source   rsp_if
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [1:0]           status_ff, status_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 bank_ff, bank_in;
   logic [2*ELEMS-1:0]   valid_ff, valid_in;
   logic                 sat_ff, sat_in;

   logic signed [WORD_BITS-1:0] px_ff, py_ff, pz_ff;
   logic signed [WORD_BITS-1:0] qx_ff, qy_ff, qz_ff;

   mac_tag_type tag_a_ff, tag_a_in;
   mac_tag_type tag_b_ff, tag_c_ff;

   // matrix storage: current matrix in two banks, operand matrix
   logic signed [WORD_BITS-1:0] cur_mem [0:2*ELEMS-1];
   logic signed [WORD_BITS-1:0] opd_mem [0:ELEMS-1];

   logic signed [WORD_BITS-1:0] cur_rd_ff, opd_rd_ff;
   logic                        cur_hit_ff, cur_diag_ff;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;

   logic                 rsp_valid_ff;
   logic [1:0]           rsp_status_ff;
   logic                 rsp_sat_ff;
   logic signed [31:0]   rsp_qx_ff, rsp_qy_ff, rsp_qz_ff;

   logic                 req_fire, rsp_load, is_mul;
   logic [1:0]           step_k, step_r, step_c;
   logic [IDX_BITS:0]    cur_raddr;
   logic [IDX_BITS-1:0]  opd_raddr;
   logic                 last_step, pipe_empty;
   logic signed [WORD_BITS-1:0] mul_a, mul_b, point_k;
   logic signed [ACC_BITS-1:0]  acc_shift;
   logic                 clamp_hi, clamp_lo, cur_we;
   logic signed [WORD_BITS-1:0] fin_val;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign is_mul       = (status_ff == STATUS_MULTIPLIED);

   // step decode: c in the top bits, then r, k innermost
   assign step_k    = step_ff[1:0];
   assign step_r    = step_ff[3:2];
   assign step_c    = step_ff[5:4];
   assign cur_raddr = {bank_ff, step_k, step_r};
   assign opd_raddr = {step_c, step_k};
   assign last_step = is_mul ? (step_ff == MUL_LAST_STEP) : (step_ff == XFORM_LAST_STEP);
   assign pipe_empty = !(tag_a_ff.live || tag_b_ff.live || tag_c_ff.live);

   // issue tag for the step in flight
   always_comb begin
      tag_a_in.live = (state_ff == ST_RUN);
      tag_a_in.k    = step_k;
      tag_a_in.dest = {step_c, step_r};
   end

   // sequencer and control state
   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      step_in   = step_ff;
      bank_in   = bank_ff;
      valid_in  = valid_ff;
      sat_in    = sat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               step_in   = '0;
               sat_in    = 1'b0;
               status_in = STATUS_ACCEPTED;
               state_in  = ST_DONE;
               case (req_if.func)
                  FUNC_IDENTITY: begin
                     valid_in = '0;
                     bank_in  = 1'b0;
                  end
                  FUNC_LOAD: begin
                     if (req_if.elem_last) begin
                        status_in = STATUS_MULTIPLIED;
                        state_in  = ST_RUN;
                     end
                  end
                  FUNC_TRANSFORM: begin
                     status_in = STATUS_TRANSFORMED;
                     state_in  = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (pipe_empty) begin
               if (is_mul) begin
                  bank_in = !bank_ff;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // round stage results
      if (tag_c_ff.live) begin
         sat_in = sat_in || clamp_hi || clamp_lo;
         if (cur_we) begin
            valid_in[{!bank_ff, tag_c_ff.dest}] = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         status_ff <= STATUS_ACCEPTED;
         step_ff   <= '0;
         bank_ff   <= 1'b0;
         valid_ff  <= '0;
         sat_ff    <= 1'b0;
         tag_a_ff  <= '0;
         tag_b_ff  <= '0;
         tag_c_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         step_ff   <= step_in;
         bank_ff   <= bank_in;
         valid_ff  <= valid_in;
         sat_ff    <= sat_in;
         tag_a_ff  <= tag_a_in;
         tag_b_ff  <= tag_a_ff;
         tag_c_ff  <= '{live: tag_b_ff.live && (tag_b_ff.k == 2'd3),
                        k: tag_b_ff.k, dest: tag_b_ff.dest};
      end
   end

   // latch point coordinates
   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff <= word_from_in(req_if.px);
         py_ff <= word_from_in(req_if.py);
         pz_ff <= word_from_in(req_if.pz);
      end
   end

   // operand memory: written on load transactions, read by the sequencer
   always_ff @(posedge clock) begin
      if (req_fire && (req_if.func == FUNC_LOAD)) begin
         opd_mem[req_if.elem_index] <= word_from_in(req_if.elem_value);
      end
      opd_rd_ff <= opd_mem[opd_raddr];
   end

   // current matrix memory: read from the live bank, results go to the other bank
   assign cur_we = tag_c_ff.live && is_mul;
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem[{!bank_ff, tag_c_ff.dest}] <= fin_val;
      end
      cur_rd_ff   <= cur_mem[cur_raddr];
      cur_hit_ff  <= valid_ff[cur_raddr];
      cur_diag_ff <= (step_k == step_r);
   end

   // multiply stage: entries not written since reset or the last identity request read as identity
   always_comb begin
      case (tag_a_ff.k)
         2'd0:    point_k = px_ff;
         2'd1:    point_k = py_ff;
         2'd2:    point_k = pz_ff;
         default: point_k = '0;
      endcase
      if (cur_hit_ff) begin
         mul_a = cur_rd_ff;
      end else begin
         mul_a = cur_diag_ff ? IDENT_ONE : '0;
      end
      mul_b   = is_mul ? opd_rd_ff : point_k;
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (tag_a_ff.live) begin
         prod_ff <= prod_in;
      end
   end

   // accumulate stage, restarting on the first term of each dot product
   assign acc_in = ((tag_b_ff.k == 2'd0) ? '0 : acc_ff) + ACC_BITS'(prod_ff);

   always_ff @(posedge clock) begin
      if (tag_b_ff.live) begin
         acc_ff <= acc_in;
      end
   end

   // round stage: floor shift and saturate to the word range
   assign acc_shift = acc_ff >>> FRAC_BITS;
   assign clamp_hi  = acc_shift > ACC_BITS'(WORD_MAX);
   assign clamp_lo  = acc_shift < ACC_BITS'(WORD_MIN);
   always_comb begin
      if (clamp_hi) begin
         fin_val = WORD_MAX;
      end else if (clamp_lo) begin
         fin_val = WORD_MIN;
      end else begin
         fin_val = acc_shift[WORD_BITS-1:0];
      end
   end

   // transformed point components
   always_ff @(posedge clock) begin
      if (tag_c_ff.live && !is_mul) begin
         case (tag_c_ff.dest[1:0])
            2'd0:    qx_ff <= fin_val;
            2'd1:    qy_ff <= fin_val;
            default: qz_ff <= fin_val;
         endcase
      end
   end

   // response register
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_sat_ff    <= sat_ff;
         if (status_ff == STATUS_TRANSFORMED) begin
            rsp_qx_ff <= out_from_word(qx_ff);
            rsp_qy_ff <= out_from_word(qy_ff);
            rsp_qz_ff <= out_from_word(qz_ff);
         end else begin
            rsp_qx_ff <= '0;
            rsp_qy_ff <= '0;
            rsp_qz_ff <= '0;
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.saturated = rsp_sat_ff;
   assign rsp_if.qx        = rsp_qx_ff;
   assign rsp_if.qy        = rsp_qy_ff;
   assign rsp_if.qz        = rsp_qz_ff;

   // pipeline holds nothing while waiting for a request
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> pipe_empty)
      else $error("mac pipeline busy while idle");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready)
      else $error("request accepted back to back");

   // point fields are zero unless the response is a transform
   a_q_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_TRANSFORMED)) |->
      ((rsp_qx_ff == '0) && (rsp_qy_ff == '0) && (rsp_qz_ff == '0)))
      else $error("nonzero point on non-transform response");

   // current matrix is written only by a multiply, never from the idle state
   a_cur_write_mul: assert property (@(posedge clock) disable iff (reset)
      cur_we |-> ((state_ff == ST_RUN) || (state_ff == ST_DRAIN)))
      else $error("current matrix written outside a multiply");

endmodule
